// File: hdl/pida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg
// Shared widths, codes and types for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

   localparam int CAPACITY_DEFAULT = 128;
   localparam int KIND_W           = 2;
   localparam int POS_W            = 8;
   localparam int DATA_W           = 32;
   localparam int STATUS_W         = 2;
   localparam int FILL_W           = 8;
   localparam int GROUP            = 16;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// File: hdl/pida_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_req_if / pida_rsp_if
// Valid/ready channels for operation requests and their responses.
// ----------------------------------------------------------------------------
interface pida_req_if import pida_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pida_rsp_if import pida_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] read_value;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, status, read_value, fill_count, input ready);
   modport sink   (input valid, status, read_value, fill_count, output ready);
endinterface

// File: hdl/pida_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_cell
// One array entry. Shifts up from its left neighbor on insert, down from its
// right neighbor on delete, and offers its entry when the position hits it.
// ----------------------------------------------------------------------------
module pida_cell import pida_pkg::*; #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] hit_data
);

   localparam logic [IDX_W-1:0] MyIndex = IDX_W'(INDEX);

   logic [IDX_W-1:0]         pos_ext;
   logic                     at_pos;
   logic                     above_pos;
   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   assign pos_ext   = IDX_W'(ctrl.position);
   assign at_pos    = (MyIndex == pos_ext);
   assign above_pos = (MyIndex > pos_ext);

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (at_pos) data_in = ctrl.value;
         else if (above_pos) data_in = left_data;
      end else if (ctrl.remove) begin
         if (at_pos || above_pos) data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign hit_data = at_pos ? data_ff : '0;

endmodule

// File: hdl/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Packed array with a fill count; insert, delete and read at a position.
// ----------------------------------------------------------------------------
// Every entry lives in a cell of a chain; an insert or delete shifts the cells at
// and above the position in the cycle the beat is accepted, so the block takes one
// request per clock while the pending stage can advance. The read hits of each
// group of 16 cells are reduced into a group register as the request is accepted,
// then the groups are merged into the response register. Requests keep
// flowing while a response waits, until the single pending stage is also
// occupied. The array contents are not cleared at reset; only the fill count and valid flags.
module positional_insert_delete_array import pida_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pida_req_if.sink    req_ch,
   pida_rsp_if.source  rsp_ch
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
   localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, rsp_free;
   logic [CMP_W-1:0] pos_c, cnt_c;
   logic             is_ins, is_del, is_rd, ins_ok, del_ok, rd_ok, cnt_zero;
   logic [STATUS_W-1:0] status_in;
   cell_ctrl_type    ctrl;

   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] cell_hit  [CAPACITY];
   logic signed [DATA_W-1:0] grp_ff    [NGROUP];
   logic signed [DATA_W-1:0] grp_in    [NGROUP];

   logic                pend_valid_ff;
   logic [STATUS_W-1:0] pend_status_ff;
   logic [FILL_W-1:0]   pend_fill_ff;
   logic                pend_rd_ok_ff;
   logic signed [DATA_W-1:0] merged;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [FILL_W-1:0]        rsp_fill_ff;

   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !pend_valid_ff || rsp_free;
   assign accept        = req_ch.valid && req_ch.ready;

   // decode the beat against the current fill count
   assign pos_c    = CMP_W'(req_ch.position);
   assign cnt_c    = CMP_W'(count_ff);
   assign cnt_zero = (count_ff == '0);
   assign is_ins   = (req_ch.kind == KIND_INSERT);
   assign is_del   = (req_ch.kind == KIND_DELETE);
   assign is_rd    = (req_ch.kind == KIND_READ);
   assign ins_ok   = is_ins && (pos_c <= cnt_c) && (count_ff != CapCount);
   assign del_ok   = is_del && !cnt_zero && (pos_c < cnt_c);
   assign rd_ok    = is_rd  && !cnt_zero && (pos_c < cnt_c);

   always_comb begin
      status_in = STATUS_OK;
      priority if (is_ins) begin
         if (pos_c > cnt_c) status_in = STATUS_BADPOS;
         else if (count_ff == CapCount) status_in = STATUS_FULL;
      end else if (is_del || is_rd) begin
         if (cnt_zero) status_in = STATUS_EMPTY;
         else if (pos_c >= cnt_c) status_in = STATUS_BADPOS;
      end else begin
         status_in = STATUS_BADPOS;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && ins_ok) count_in = count_ff + 1'b1;
      else if (accept && del_ok) count_in = count_ff - 1'b1;
   end

   assign ctrl.insert   = accept && ins_ok;
   assign ctrl.remove   = accept && del_ok;
   assign ctrl.position = req_ch.position;
   assign ctrl.value    = req_ch.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = req_ch.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_inner
         assign right_d = cell_data[i+1];
      end
      pida_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .hit_data   (cell_hit[i])
      );
   end

   // first level of the read tree: one OR per group of cells
   for (genvar g = 0; g < NGROUP; g++) begin : g_grp
      always_comb begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            if (g * GROUP + j < CAPACITY) grp_in[g] = grp_in[g] | cell_hit[g * GROUP + j];
         end
      end
   end

   always_comb begin
      merged = '0;
      for (int g = 0; g < NGROUP; g++) begin
         merged = merged | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) pend_valid_ff <= 1'b1;
         else if (rsp_free) pend_valid_ff <= 1'b0;
         if (pend_valid_ff && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         pend_status_ff <= status_in;
         pend_fill_ff   <= FILL_W'(count_in);
         pend_rd_ok_ff  <= rd_ok;
         for (int g = 0; g < NGROUP; g++) grp_ff[g] <= grp_in[g];
      end
      // advance the pending beat into the response register
      if (pend_valid_ff && rsp_free) begin
         rsp_status_ff <= pend_status_ff;
         rsp_fill_ff   <= pend_fill_ff;
         rsp_value_ff  <= pend_rd_ok_ff ? merged : '0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.fill_count = rsp_fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("fill count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("good insert did not grow the count");

   a_pend_moves: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_free) |=> rsp_valid_ff)
      else $error("pending beat not moved to response");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !pend_valid_ff |-> req_ch.ready)
      else $error("request stalled with empty pending stage");

endmodule
